// ===== rtl/core/fcpa_pkg.sv =====
// Shared types and constants of the fixed chunk pool allocator.
// Holds field widths, status and command codes, register map and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package fcpa_pkg;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int CHUNK_W  = 16;
  localparam int POOL_W   = 24;
  localparam int SIZE_W   = 16;
  localparam int ALIGN_W  = 13;
  localparam int STATUS_W = 3;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Default pool capacity in chunks
  localparam int DEF_MAX_CHUNKS = 1024;

  // Register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [CHUNK_W-1:0] CHUNK_RST = 16'd8;
  localparam logic [POOL_W-1:0]  POOL_RST  = 24'd80;

  // Register indexes (word address)
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_CHUNK = 2'd1;
  localparam logic [1:0] REG_POOL  = 2'd2;

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_OUTSIDE    = 3'd4
  } fcpa_status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         load_in;
    logic         mul_go;
    logic         div_start;
    logic         rd_link;
    logic         pop;
    logic         push;
    logic         fresh_inc;
    logic         res_load;
    logic         res_grant;
    fcpa_status_t res_status;
  } fcpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_free;
    logic chunk_zero;
    logic use_rec;
    logic fresh_ok;
    logic div_busy;
    logic too_large;
    logic rem_nz;
    logic outside;
  } fcpa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcpa_if.sv =====
// Valid/ready channel interfaces for request and result transfers.
// Depends on fcpa_pkg for field widths.
`default_nettype none

interface fcpa_in_if;
  import fcpa_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SIZE_W-1:0]  request_size;
  logic [ALIGN_W-1:0] align_bytes;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, cmd, request_size, align_bytes, free_address,
                  input ready);
  modport sink   (input valid, cmd, request_size, align_bytes, free_address,
                  output ready);
endinterface

interface fcpa_out_if;
  import fcpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fcpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/fcpa_div.sv =====
// Restoring radix-2 divider: 32-bit dividend by 16-bit divisor, one bit
// per cycle. Depends on fcpa_pkg for widths.
`default_nettype none

module fcpa_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [fcpa_pkg::ADDR_W-1:0]  dividend,
  input  wire logic [fcpa_pkg::CHUNK_W-1:0] divisor,
  output logic                              busy,
  output logic      [fcpa_pkg::ADDR_W-1:0]  quot,
  output logic      [fcpa_pkg::CHUNK_W-1:0] rem
);
  import fcpa_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  q_r, q_nxt;
  logic [CHUNK_W-1:0] rem_r, rem_nxt;
  logic [CHUNK_W-1:0] dvs_r;
  logic [CHUNK_W:0]   trial;
  logic               fits;

  // One restoring step: bring down the next dividend bit and try a subtract
  assign trial = {rem_r, q_r[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(ADDR_W);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      q_nxt   = {q_r[ADDR_W-2:0], fits};
      rem_nxt = fits ? CHUNK_W'(trial - {1'b0, dvs_r}) : trial[CHUNK_W-1:0];
    end
  end

  // Hold the iteration count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Advance the partial quotient and remainder
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy = cnt_r != '0;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/fcpa_dp.sv =====
// Allocator datapath: request capture, chunk address multiply, shared
// divider, free-list head/depth/fresh counters, link RAM and result register.
// Depends on fcpa_pkg, fcpa_div and fcpa_ram.
`default_nettype none

module fcpa_dp #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fcpa_pkg::fcpa_cmd_t           ctl_cmd,
  output fcpa_pkg::fcpa_stat_t               stat,
  // Configuration
  input  wire logic [fcpa_pkg::ADDR_W-1:0]   base_address,
  input  wire logic [fcpa_pkg::CHUNK_W-1:0]  chunk_bytes,
  input  wire logic [fcpa_pkg::POOL_W-1:0]   pool_bytes,
  // Request payload
  input  wire logic                          req_cmd,
  input  wire logic [fcpa_pkg::SIZE_W-1:0]   req_size,
  input  wire logic [fcpa_pkg::ALIGN_W-1:0]  req_align,
  input  wire logic [fcpa_pkg::ADDR_W-1:0]   req_free_addr,
  // Result payload
  output logic      [fcpa_pkg::STATUS_W-1:0] res_status,
  output logic      [fcpa_pkg::ADDR_W-1:0]   res_granted
);
  import fcpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int PROD_W = CNT_W + CHUNK_W;
  localparam int PCMP_W = (PROD_W > POOL_W) ? PROD_W : POOL_W;

  // Request registers
  logic               cmd_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ALIGN_W-1:0] align_r;
  logic [ADDR_W-1:0]  faddr_r;

  // Free list state
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   depth_r, depth_nxt;
  logic [CNT_W-1:0]   fresh_r, fresh_nxt;

  // Work registers
  logic               use_rec_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ADDR_W-1:0]  op_r;

  // Result registers
  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   res_granted_r;

  logic [ALIGN_W-1:0] align_eff;
  logic [CNT_W-1:0]   mul_op;
  logic [ADDR_W-1:0]  dividend;
  logic [CHUNK_W-1:0] divisor;
  logic               div_busy;
  logic [ADDR_W-1:0]  quot;
  logic [CHUNK_W-1:0] rem;
  logic [ALIGN_W-1:0] pad;
  logic [CHUNK_W:0]   pad_sum;
  logic [ADDR_W-1:0]  granted;
  logic [IDX_W-1:0]   link_rdata;

  // Alignment of zero means no padding
  assign align_eff = (align_r == '0) ? ALIGN_W'(1) : align_r;

  // Candidate chunk index for the multiply: recycled head or next fresh chunk
  assign mul_op = (depth_r != '0) ? CNT_W'(head_r) : fresh_r;

  // Divider operands: chunk offset for free, chunk address for allocate
  assign dividend = (cmd_r == CMD_FREE) ? (faddr_r - base_address)
                                        : (base_address + ADDR_W'(prod_r));
  assign divisor  = (cmd_r == CMD_FREE) ? chunk_bytes : CHUNK_W'(align_eff);

  // Padding up to the alignment and fit check
  assign pad     = (rem == '0) ? '0 : (align_eff - rem[ALIGN_W-1:0]);
  assign pad_sum = (CHUNK_W+1)'(pad) + (CHUNK_W+1)'(size_r);
  assign granted = op_r + ADDR_W'(pad);

  // Capture the request
  always_ff @(posedge clk) begin
    if (ctl_cmd.load_in) begin
      cmd_r   <= req_cmd;
      size_r  <= req_size;
      align_r <= req_align;
      faddr_r <= req_free_addr;
    end
  end

  // Register the source pick and chunk multiply, then the divider operand
  always_ff @(posedge clk) begin
    if (ctl_cmd.mul_go) begin
      use_rec_r <= depth_r != '0;
      prod_r    <= PROD_W'(mul_op) * PROD_W'(chunk_bytes);
    end
    if (ctl_cmd.div_start) begin
      op_r <= dividend;
    end
  end

  fcpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl_cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  // Link store: next index of each recycled chunk
  fcpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CHUNKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ctl_cmd.push),
    .waddr (quot[IDX_W-1:0]),
    .wdata (head_r),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  // Free list updates: pop, push, fresh advance
  always_comb begin
    head_nxt  = head_r;
    depth_nxt = depth_r;
    fresh_nxt = fresh_r;
    if (ctl_cmd.pop) begin
      head_nxt  = link_rdata;
      depth_nxt = depth_r - 1'b1;
    end else if (ctl_cmd.push) begin
      head_nxt = quot[IDX_W-1:0];
      if (depth_r != CNT_W'(MAX_CHUNKS)) begin
        depth_nxt = depth_r + 1'b1;
      end
    end
    if (ctl_cmd.fresh_inc) begin
      fresh_nxt = fresh_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      depth_r <= '0;
      fresh_r <= '0;
    end else begin
      head_r  <= head_nxt;
      depth_r <= depth_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl_cmd.res_load) begin
      res_status_r  <= ctl_cmd.res_status;
      res_granted_r <= ctl_cmd.res_grant ? granted : '0;
    end
  end

  assign res_status  = res_status_r;
  assign res_granted = res_granted_r;

  // Status back to the controller
  assign stat.is_free    = cmd_r == CMD_FREE;
  assign stat.chunk_zero = chunk_bytes == '0;
  assign stat.use_rec    = use_rec_r;
  assign stat.fresh_ok   = (chunk_bytes != '0) && (fresh_r < CNT_W'(MAX_CHUNKS))
                         && (PCMP_W'(prod_r) < PCMP_W'(pool_bytes));
  assign stat.div_busy   = div_busy;
  assign stat.too_large  = pad_sum > (CHUNK_W+1)'(chunk_bytes);
  assign stat.rem_nz     = rem != '0;
  assign stat.outside    = (op_r >= ADDR_W'(pool_bytes))
                         || (quot >= ADDR_W'(MAX_CHUNKS));

endmodule

`default_nettype wire

// ===== rtl/core/fcpa_ctrl.sv =====
// Allocator controller: sequences one request through multiply, divide,
// evaluate and link access, then hands the result to the output register.
// Depends on fcpa_pkg.
`default_nettype none

module fcpa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire fcpa_pkg::fcpa_stat_t stat,
  output fcpa_pkg::fcpa_cmd_t       ctl_cmd
);
  import fcpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_EVAL,
    S_READ,
    S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  fcpa_status_t pend_st_r, pend_st_nxt;
  logic         pend_grant_r, pend_grant_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    pend_st_nxt    = pend_st_r;
    pend_grant_nxt = pend_grant_r;
    ctl_cmd        = '0;
    ctl_cmd.res_status = pend_st_r;
    ctl_cmd.res_grant  = pend_grant_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl_cmd.load_in = 1'b1;
          state_nxt       = S_MUL;
        end
      end
      S_MUL: begin
        ctl_cmd.mul_go = 1'b1;
        state_nxt      = S_START;
      end
      S_START: begin
        pend_grant_nxt = 1'b0;
        if (stat.is_free && stat.chunk_zero) begin
          pend_st_nxt = ST_OUTSIDE;
          state_nxt   = S_DONE;
        end else if (!stat.is_free && !stat.use_rec && !stat.fresh_ok) begin
          pend_st_nxt = ST_EMPTY;
          state_nxt   = S_DONE;
        end else begin
          ctl_cmd.div_start = 1'b1;
          state_nxt         = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_free) begin
          if (stat.rem_nz) begin
            pend_st_nxt = ST_MISALIGNED;
          end else if (stat.outside) begin
            pend_st_nxt = ST_OUTSIDE;
          end else begin
            ctl_cmd.push = 1'b1;
            pend_st_nxt  = ST_OK;
          end
          state_nxt = S_DONE;
        end else if (stat.too_large) begin
          pend_st_nxt = ST_TOO_LARGE;
          state_nxt   = S_DONE;
        end else if (stat.use_rec) begin
          ctl_cmd.rd_link = 1'b1;
          state_nxt       = S_READ;
        end else begin
          ctl_cmd.fresh_inc = 1'b1;
          pend_st_nxt       = ST_OK;
          pend_grant_nxt    = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      S_READ: begin
        ctl_cmd.pop    = 1'b1;
        pend_st_nxt    = ST_OK;
        pend_grant_nxt = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_cmd.res_load = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on result load, drop on transfer
  always_comb begin
    if (ctl_cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_st_r    <= ST_OK;
      pend_grant_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_st_r    <= pend_st_nxt;
      pend_grant_r <= pend_grant_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_chunk_pool_allocator.sv =====
// Top level of the fixed chunk pool allocator: APB register file and the
// controller/datapath pair. Depends on fcpa_pkg, fcpa_if, fcpa_ctrl, fcpa_dp.
//
//   Channel   Direction  Handshake        Carries
//   in_ch     sink       valid/ready      cmd, request_size, align_bytes, free_address
//   out_ch    source     valid/ready      status, granted_address
//   APB       slave      psel/penable     base_address, chunk_bytes, pool_bytes
//
// One request at a time. A request that reaches the divider passes the multiply,
// start, divide and evaluate states, plus the link read state for a recycled
// chunk; the 32-step bit-serial divider runs in the divide state. Pool-empty
// allocates and zero-chunk-size frees skip the divider. The result sits in an output
// register; a new request is taken while it waits, and a finished request holds
// until the register is free. Synchronous active-low reset clears the free list.
`default_nettype none

module fixed_chunk_pool_allocator #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fcpa_in_if.sink                          in_ch,
  fcpa_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fcpa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [fcpa_pkg::CFG_DW-1:0] pwdata,
  output logic      [fcpa_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import fcpa_pkg::*;

  logic [ADDR_W-1:0]  base_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [POOL_W-1:0]  pool_r;
  logic               wr_en;
  logic [1:0]         reg_idx;
  fcpa_cmd_t          ctl_cmd;
  fcpa_stat_t         stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      chunk_r <= CHUNK_RST;
      pool_r  <= POOL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE:  base_r  <= pwdata[ADDR_W-1:0];
        REG_CHUNK: chunk_r <= pwdata[CHUNK_W-1:0];
        REG_POOL:  pool_r  <= pwdata[POOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_BASE:  prdata = CFG_DW'(base_r);
      REG_CHUNK: prdata = CFG_DW'(chunk_r);
      REG_POOL:  prdata = CFG_DW'(pool_r);
      default:   prdata = '0;
    endcase
  end

  fcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl_cmd   (ctl_cmd)
  );

  fcpa_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_cmd       (ctl_cmd),
    .stat          (stat),
    .base_address  (base_r),
    .chunk_bytes   (chunk_r),
    .pool_bytes    (pool_r),
    .req_cmd       (in_ch.cmd),
    .req_size      (in_ch.request_size),
    .req_align     (in_ch.align_bytes),
    .req_free_addr (in_ch.free_address),
    .res_status    (out_ch.status),
    .res_granted   (out_ch.granted_address)
  );

endmodule

`default_nettype wire
